// File: sv/ddo_pkg.sv
// ddo_pkg: shared constants, arctangent table and controller/datapath
// command and status types for the differential-drive odometry block
// no dependencies
`timescale 1ns / 1ps

package ddo_pkg;

  // default build settings
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int TABLE_LEN        = 24;

  // register reset value and cordic gain compensation (Q2.30)
  localparam logic [17:0] TURN_GAIN_RST = 18'd65124;
  localparam logic [31:0] CORDIC_K_Q30  = 32'd652032874;

  // arctangent of 2^-i, 2^32 units per turn
  localparam logic [31:0] ATAN_TURN_Q32 [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // table entry rounded to abits bits per turn
  function automatic logic [31:0] atan_step(input logic [4:0] idx, input int abits);
    logic [63:0] v;
    logic [63:0] s;
    v = {32'd0, ATAN_TURN_Q32[idx]} + (64'd1 << (31 - abits));
    s = v >> (32 - abits);
    return s[31:0];
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic mul;
    logic angle;
    logic rot;
    logic proj_x;
    logic proj_y;
    logic commit;
  } ddo_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic rot_last;
  } ddo_sts_t;

endpackage

// File: sv/ddo_ctrl.sv
// ddo_ctrl: sequencer for one odometry update and the output handshake
// depends on ddo_pkg (command and status types)
`timescale 1ns / 1ps

module ddo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ddo_pkg::ddo_sts_t sts,
  output ddo_pkg::ddo_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_ANGLE  = 7'b0000100,
    S_ROT    = 7'b0001000,
    S_PROJX  = 7'b0010000,
    S_PROJY  = 7'b0100000,
    S_COMMIT = 7'b1000000
  } ddo_state_t;

  ddo_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // result slot can take a new word when empty or being drained
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_ANGLE;
      S_ANGLE:  state_nxt = S_ROT;
      S_ROT:    if (sts.rot_last) state_nxt = S_PROJX;
      S_PROJX:  state_nxt = S_PROJY;
      S_PROJY:  state_nxt = S_COMMIT;
      S_COMMIT: if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.load_in = (state_r == S_IDLE) && in_valid;
    cmd.mul     = (state_r == S_MUL);
    cmd.angle   = (state_r == S_ANGLE);
    cmd.rot     = (state_r == S_ROT);
    cmd.proj_x  = (state_r == S_PROJX);
    cmd.proj_y  = (state_r == S_PROJY);
    cmd.commit  = (state_r == S_COMMIT) && slot_free;
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/ddo_dpath.sv
// ddo_dpath: heading math, iterative cordic, projection multiplier and
// saturating pose accumulators; depends on ddo_pkg
`timescale 1ns / 1ps

module ddo_dpath #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [17:0]        cfg_write_data,
  input  logic signed [15:0] in_left_distance,
  input  logic signed [15:0] in_right_distance,
  input  ddo_pkg::ddo_cmd_t  cmd,
  output ddo_pkg::ddo_sts_t  sts,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic [15:0]        out_heading_angle
);

  localparam int ZW = ANGLE_BITS + 2;
  localparam int XW = 34;
  localparam int SW = $clog2(CORDIC_STEPS);
  localparam int PW = 51;

  logic [17:0]          turn_gain_r;
  logic signed [16:0]   diff_r, sum_r;
  logic signed [35:0]   prod_r;
  logic [15:0]          change_r;
  logic                 flip_r;
  logic signed [ZW-1:0] z_r;
  logic signed [XW-1:0] x_r, y_r;
  logic [SW-1:0]        step_r;
  logic signed [PW-1:0] pp_r;
  logic signed [19:0]   dx_r;
  logic signed [31:0]   pose_x_r, pose_y_r;
  logic [15:0]          heading_r;

  // turn gain register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_gain_r <= ddo_pkg::TURN_GAIN_RST;
    end else if (cfg_write_en) begin
      turn_gain_r <= cfg_write_data;
    end
  end

  // wheel difference times gain, rounded heading change
  logic signed [18:0] gain_s;
  logic signed [35:0] prod_nxt;
  logic signed [35:0] prod_rnd;
  logic [15:0]        change_nxt;
  assign gain_s     = $signed({1'b0, turn_gain_r});
  assign prod_nxt   = diff_r * gain_s;
  assign prod_rnd   = prod_r + 36'sd32768;
  assign change_nxt = prod_rnd[31:16];

  // midpoint heading, folded into a quarter turn either side of zero
  logic signed [15:0] w_half;
  logic [15:0]        mid;
  logic signed [15:0] sa_raw, sa;
  logic               flip_nxt;
  logic signed [31:0] sa_w;
  logic signed [ZW-1:0] z_init;
  assign w_half   = $signed(change_nxt) >>> 1;
  assign mid      = heading_r + w_half;
  assign sa_raw   = $signed(mid);
  assign flip_nxt = (sa_raw > 16'sd16384) || (sa_raw < -16'sd16384);
  assign sa       = flip_nxt ? $signed({~mid[15], mid[14:0]}) : sa_raw;
  assign sa_w     = 32'(sa);

  // angle scaled to ANGLE_BITS per turn
  generate
    if (ANGLE_BITS >= 16) begin : g_up
      assign z_init = ZW'(sa_w <<< (ANGLE_BITS - 16));
    end else begin : g_dn
      assign z_init = ZW'(sa_w >>> (16 - ANGLE_BITS));
    end
  endgenerate

  // one rotation step per cycle
  logic [31:0]          t_full;
  logic signed [ZW-1:0] t_z;
  logic signed [XW-1:0] xs, ys;
  assign t_full   = ddo_pkg::atan_step(5'(step_r), ANGLE_BITS);
  assign t_z      = $signed(ZW'(t_full));
  assign xs       = x_r >>> step_r;
  assign ys       = y_r >>> step_r;
  assign sts.rot_last = (step_r == SW'(CORDIC_STEPS - 1));

  // projection of the mean travel onto cosine and sine
  logic signed [XW-1:0] cs_sel, cs_fix;
  logic signed [PW-1:0] pp_nxt, pp_rnd;
  logic signed [19:0]   d_cur;
  assign cs_sel = cmd.proj_x ? x_r : y_r;
  assign cs_fix = flip_r ? -cs_sel : cs_sel;
  assign pp_nxt = sum_r * cs_fix;
  assign pp_rnd = pp_r + 51'sd1073741824;
  assign d_cur  = 20'(pp_rnd >>> 31);

  // saturating pose add
  logic signed [32:0] sx, sy;
  logic signed [31:0] nx, ny;
  assign sx = 33'(pose_x_r) + 33'(dx_r);
  assign sy = 33'(pose_y_r) + 33'(d_cur);
  always_comb begin
    nx = sx[31:0];
    ny = sy[31:0];
    if (sx[32] != sx[31]) nx = sx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    if (sy[32] != sy[31]) ny = sy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      diff_r <= 17'(in_right_distance) - 17'(in_left_distance);
      sum_r  <= 17'(in_right_distance) + 17'(in_left_distance);
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.angle) begin
      change_r <= change_nxt;
      flip_r   <= flip_nxt;
      z_r      <= z_init;
      x_r      <= XW'(ddo_pkg::CORDIC_K_Q30);
      y_r      <= '0;
      step_r   <= '0;
    end
    if (cmd.rot) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - t_z;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + t_z;
      end
      step_r <= step_r + SW'(1);
    end
    if (cmd.proj_x || cmd.proj_y) begin
      pp_r <= pp_nxt;
    end
    if (cmd.proj_y) begin
      dx_r <= d_cur;
    end
  end

  // pose state, also the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r  <= '0;
      pose_y_r  <= '0;
      heading_r <= '0;
    end else if (cmd.commit) begin
      pose_x_r  <= nx;
      pose_y_r  <= ny;
      heading_r <= heading_r + change_r;
    end
  end

  assign out_position_x    = pose_x_r;
  assign out_position_y    = pose_y_r;
  assign out_heading_angle = heading_r;

endmodule

// File: sv/differential_drive_odometry.sv
// differential_drive_odometry: top level of the dead-reckoning pose tracker
// depends on ddo_pkg, ddo_ctrl and ddo_dpath
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word of signed left and
//   right wheel travel in 1/256 cm. Each word yields exactly one result
//   word on the output channel (out_valid/out_ready): the new x and y
//   position (saturating, 1/256 cm) and the heading as a binary angle.
//   cfg_write_en/cfg_write_data load the Q2.16 turn gain; write it only
//   while no word is in flight.
//   After input acceptance each word passes through the gain multiply,
//   the angle setup, CORDIC_STEPS rotation steps of the iterative cordic
//   (one step per cycle), two projection multiplies and the commit, which
//   raises out_valid. One word is processed at a time: in_ready is high
//   while the sequencer is idle, so a new word is taken only after the
//   previous one has been committed.
//   Reset clears the pose and heading to zero and restores the turn gain
//   to 65124. If the receiver stalls, the result word is held and the next
//   input word is still accepted and processed; its pose update waits until
//   the held word is taken.
`timescale 1ns / 1ps

module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [17:0]        cfg_write_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_left_distance,
  input  logic signed [15:0] in_right_distance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic [15:0]        out_heading_angle
);

  ddo_pkg::ddo_cmd_t cmd;
  ddo_pkg::ddo_sts_t sts;

  // sequencer
  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and pose state
  ddo_dpath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_left_distance  (in_left_distance),
    .in_right_distance (in_right_distance),
    .cmd               (cmd),
    .sts               (sts),
    .out_position_x    (out_position_x),
    .out_position_y    (out_position_y),
    .out_heading_angle (out_heading_angle)
  );

endmodule

// File: bench/tb.sv
// tb: self-checking bench for the differential-drive odometry block
// drives random and directed wheel-travel words against an internal pose predictor
// depends on differential_drive_odometry and its sub-blocks only
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF    = 5;
  localparam int STEPS       = 16;
  localparam int ANG_BITS    = 16;
  localparam int LATENCY     = STEPS + 5;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int STRAIGHT_WORDS = 60;
  localparam int LONG_HOLD   = 400;

  localparam logic [17:0] GAIN_AT_RESET = 18'd65124;
  localparam logic [17:0] GAIN_UNITY    = 18'd65536;
  localparam logic [17:0] GAIN_MAX      = 18'h3FFFF;
  localparam longint      VEC_START_Q30 = 64'sd652032874;
  localparam longint      POS_MAX       = 64'sd2147483647;
  localparam longint      POS_MIN       = -64'sd2147483648;

  // arctangent of 2^-i, 2^32 units per turn
  localparam longint ARCTAN_Q32 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } wheel_travel_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        heading;
  } pose_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_write_en = 1'b0;
  logic [17:0]        cfg_write_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_left_distance = '0;
  logic signed [15:0] in_right_distance = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_position_x;
  logic signed [31:0] out_position_y;
  logic [15:0]        out_heading_angle;

  // predictor state
  logic [17:0]        gain_q = GAIN_AT_RESET;
  logic signed [31:0] pose_x_q = '0;
  logic signed [31:0] pose_y_q = '0;
  logic [15:0]        heading_q = '0;

  wheel_travel_t wheel_words[$];
  pose_t         expected_poses[$];
  int            mismatches = 0;
  longint        cycle_count = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  bit            steady_run = 1'b0;
  bit            hold_armed = 1'b0;
  bit            long_hold_done = 1'b0;
  logic          quiet;

  differential_drive_odometry u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_left_distance (in_left_distance),
    .in_right_distance(in_right_distance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position_x   (out_position_x),
    .out_position_y   (out_position_y),
    .out_heading_angle(out_heading_angle)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // periodic stretches in which neither side starts a new random idle gap
  assign quiet = (cycle_count[11:10] == 2'b00);

  // cosine and sine of a binary angle, Q2.30, by iterative rotation
  function automatic void rotate_unit(input logic [15:0] ang, output longint c,
                                      output longint s);
    logic signed [15:0] sa;
    longint x, y, z, t, xs, ys;
    bit flip;
    sa = ang;
    flip = 1'b0;
    // fold into the right half plane and negate at the end
    if (sa > 16384 || sa < -16384) begin
      flip = 1'b1;
      sa = ang + 16'h8000;
    end
    if (ANG_BITS >= 16) z = longint'(sa) <<< (ANG_BITS - 16);
    else z = longint'(sa) >>> (16 - ANG_BITS);
    x = VEC_START_Q30;
    y = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      t = (ARCTAN_Q32[i] + (longint'(1) << (31 - ANG_BITS))) >> (32 - ANG_BITS);
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - t;
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + t;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [31:0] clamp_add(input logic signed [31:0] base,
                                                   input longint delta);
    longint sum;
    sum = longint'(base) + delta;
    if (sum > POS_MAX) return POS_MAX[31:0];
    if (sum < POS_MIN) return POS_MIN[31:0];
    return sum[31:0];
  endfunction

  // advance the predicted pose by one wheel-travel word
  function automatic pose_t advance_pose(input logic signed [15:0] l,
                                         input logic signed [15:0] r);
    longint prod, c, s, travel, dx, dy;
    logic [15:0] change, mid;
    logic signed [15:0] w, half_w;
    pose_t p;
    prod = (longint'(r) - longint'(l)) * longint'(gain_q);
    change = 16'((prod + 32768) >>> 16);
    w = change;
    half_w = w >>> 1;
    mid = heading_q + half_w;
    rotate_unit(mid, c, s);
    travel = longint'(l) + longint'(r);
    dx = (travel * c + (longint'(1) << 30)) >>> 31;
    dy = (travel * s + (longint'(1) << 30)) >>> 31;
    pose_x_q = clamp_add(pose_x_q, dx);
    pose_y_q = clamp_add(pose_y_q, dy);
    heading_q = heading_q + change;
    p.x = pose_x_q;
    p.y = pose_y_q;
    p.heading = heading_q;
    return p;
  endfunction

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random wheel word, mostly plausible motion with some noise
  function automatic wheel_travel_t random_travel();
    wheel_travel_t w;
    int r;
    int pick [5] = '{-32768, -1, 0, 1, 32767};
    r = $urandom_range(0, 99);
    if (r < 30) begin
      w.left = 16'($urandom);
      w.right = 16'($urandom);
    end else if (r < 55) begin
      w.left = 16'($urandom);
      w.right = w.left + 16'($urandom_range(0, 128) - 64);
    end else if (r < 70) begin
      w.left = 16'(pick[$urandom_range(0, 4)]);
      w.right = 16'(pick[$urandom_range(0, 4)]);
    end else if (r < 85) begin
      w.left = 16'($urandom_range(0, 1023) - 512);
      w.right = 16'($urandom_range(0, 1023) - 512);
    end else begin
      w.left = 16'($urandom);
      w.right = -w.left;
    end
    return w;
  endfunction

  // sender: offers queued words, random gaps between them
  always @(posedge clk) begin : drive_words
    wheel_travel_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_poses.push_back(advance_pose(in_left_distance, in_right_distance));
      end
      if (in_valid && !in_ready) begin
        // hold the word until taken
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (wheel_words.size() != 0) begin
        w = wheel_words.pop_front();
        in_valid <= 1'b1;
        in_left_distance <= w.left;
        in_right_distance <= w.right;
        if (steady_run || quiet || $urandom_range(0, 99) < 70) send_gap <= 0;
        else send_gap <= idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_armed && !long_hold_done) begin
      out_ready <= 1'b0;
      stall_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady_run || quiet || $urandom_range(0, 99) < 75) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= idle_len();
    end
  end

  // result checker
  always @(posedge clk) begin : check_poses
    pose_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: x %0d y %0d heading %0d",
                   out_position_x, out_position_y, out_heading_angle);
      end else begin
        e = expected_poses.pop_front();
        if (out_position_x !== e.x || out_position_y !== e.y ||
            out_heading_angle !== e.heading) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: x exp %0d got %0d, y exp %0d got %0d, heading exp %0d got %0d",
                     e.x, out_position_x, e.y, out_position_y, e.heading, out_heading_angle);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // wait until every queued word is taken and every result checked
  task automatic drain();
    do @(negedge clk);
    while (wheel_words.size() != 0 || in_valid || expected_poses.size() != 0);
  endtask

  task automatic write_gain(input logic [17:0] g);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= g;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    gain_q = g;
  endtask

  task automatic push(input int l, input int r);
    wheel_travel_t w;
    w.left = 16'(l);
    w.right = 16'(r);
    wheel_words.push_back(w);
  endtask

  // stimulus sequence
  initial begin : stimulus
    logic [17:0] phase_gain [4];
    int phase_len [4] = '{300, 400, 460, 460};
    logic signed [15:0] steer;
    phase_gain[0] = '0;
    phase_gain[1] = GAIN_MAX;
    phase_gain[2] = 18'($urandom_range(1, 262142));
    phase_gain[3] = 18'($urandom_range(20000, 140000));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset gain
    @(negedge clk);
    push(0, 0);
    push(32767, 32767);
    push(-32768, -32768);
    push(-32768, 32767);
    push(32767, -32768);
    push(0, 1);
    push(1, 0);
    push(-1, -1);
    // heading change of exactly a half turn, both signs
    push(-16488, 16487);
    push(16487, -16488);
    push(100, -100);
    push(256, 512);
    push(-32768, 0);
    push(0, 32767);
    push(12345, -23456);
    push(-1, 32767);
    push(32767, -1);
    push(8192, 8192);
    push(0, 16488);
    push(-20000, 20000);
    drain();

    // steer to heading zero, then drive straight at full speed back to back
    write_gain(GAIN_UNITY);
    @(negedge clk);
    steer = -heading_q;
    push(0, steer);
    drain();
    steady_run = 1'b1;
    for (int i = 0; i < STRAIGHT_WORDS; i++) push(32767, 32767);
    drain();
    steady_run = 1'b0;

    // random phases over several gain settings
    for (int p = 0; p < 4; p++) begin
      write_gain(phase_gain[p]);
      @(negedge clk);
      if (p == 2) hold_armed = 1'b1;
      for (int i = 0; i < phase_len[p]; i++) wheel_words.push_back(random_travel());
      drain();
    end

    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ddo_pkg.sv
sv/ddo_ctrl.sv
sv/ddo_dpath.sv
sv/differential_drive_odometry.sv
bench/tb.sv
